[rtl/pvm_pkg.sv]
// Package for the peer view merge block: sequencer states, table entry type,
// field widths and codes.
// No dependencies.
package pvm_pkg;

  localparam int unsigned SLOT_FW = 3;   // slot field width
  localparam int unsigned ID_W    = 11;  // peer id width
  localparam int unsigned TDATA_W = 16;  // stream data width, whole bytes

  localparam logic [ID_W-1:0] ID_EMPTY = 11'h7FF;  // -1 as a bit pattern

  localparam logic MODE_SLOT = 1'b0;  // beat writes a table slot
  localparam logic MODE_RECV = 1'b1;  // beat delivers a received id

  typedef struct packed {
    logic            mark;
    logic [ID_W-1:0] id;
  } tbl_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_M_RD,    // read received id
    ST_M_ID,    // capture id, start table scan
    ST_M_SCAN,  // compare one slot per cycle
    ST_F_RD,    // fill pass: read slot and packed tail
    ST_F_WR,    // fill pass: write back
    ST_E_RD,    // emit: read slot
    ST_E_LD,    // emit: load output register
    ST_E_OUT    // emit: hold beat until taken
  } state_e;

endpackage

[rtl/peer_view_merge.sv]
// Peer view merge: table and received-id memories with a sequencer that
// merges received ids into the neighbor table and streams the table out.
// Depends on pvm_pkg.
//
// Beats are taken only while idle. The final received id starts the merge on
// the single-port table: per stored id a read, a capture and a scan of up to
// TABLE_SLOTS table reads; then fill passes over empty, then marked slots;
// then per slot a read, a load and a hold until taken. Reset is immediate:
// per-slot valid flags make unwritten slots read empty, unmarked.
module peer_view_merge #(
  parameter int unsigned TABLE_SLOTS  = 8,
  parameter int unsigned MAX_RECEIVED = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // [2:0] slot, [13:3] peer_id, [14] replaceable, [15] zero
  input  logic [pvm_pkg::TDATA_W-1:0] s_axis_tdata,
  // [0] mode
  input  logic                        s_axis_tuser,
  input  logic                        s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [2:0] out_slot, [13:3] out_peer_id, [15:14] zero
  output logic [pvm_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic                        m_axis_tlast
);

  localparam int unsigned SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned RX_AW  = (MAX_RECEIVED > 1) ? $clog2(MAX_RECEIVED) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_RECEIVED + 1);
  localparam int unsigned SX_W   = SLOT_W + pvm_pkg::SLOT_FW;
  localparam int unsigned ID_W   = pvm_pkg::ID_W;

  // Input fields
  logic [pvm_pkg::SLOT_FW-1:0] in_slot;
  logic [ID_W-1:0]             in_id;
  logic                        in_repl;
  logic                        in_acc;
  logic [SX_W-1:0]             in_slot_x;

  assign in_slot   = s_axis_tdata[2:0];
  assign in_id     = s_axis_tdata[13:3];
  assign in_repl   = s_axis_tdata[14];
  assign in_acc    = s_axis_tvalid & s_axis_tready;
  assign in_slot_x = SX_W'(in_slot);

  // Memories
  pvm_pkg::tbl_entry_t tbl_mem [TABLE_SLOTS];
  logic [ID_W-1:0]     rx_mem  [MAX_RECEIVED];
  logic [TABLE_SLOTS-1:0] tbl_vld_q;

  logic                tbl_we;
  logic [SLOT_W-1:0]   tbl_wa;
  pvm_pkg::tbl_entry_t tbl_wd;
  logic [SLOT_W-1:0]   tbl_ra;
  pvm_pkg::tbl_entry_t tbl_rd_q;
  logic                tbl_rvld_q;
  pvm_pkg::tbl_entry_t tbl_ent;

  logic              rx_we;
  logic [RX_AW-1:0]  rx_wa;
  logic [ID_W-1:0]   rx_wd;
  logic [RX_AW-1:0]  rx_ra;
  logic [ID_W-1:0]   rx_rd_q;

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    tbl_rd_q <= tbl_mem[tbl_ra];
  end

  always_ff @(posedge clk_i) begin
    if (rx_we) begin
      rx_mem[rx_wa] <= rx_wd;
    end
    rx_rd_q <= rx_mem[rx_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_vld_q  <= '0;
      tbl_rvld_q <= 1'b0;
    end else begin
      if (tbl_we) begin
        tbl_vld_q[tbl_wa] <= 1'b1;
      end
      tbl_rvld_q <= tbl_vld_q[tbl_ra];
    end
  end

  // Never-written slot reads as empty and unmarked
  always_comb begin
    if (tbl_rvld_q) begin
      tbl_ent = tbl_rd_q;
    end else begin
      tbl_ent.mark = 1'b0;
      tbl_ent.id   = pvm_pkg::ID_EMPTY;
    end
  end

  // Sequencer registers
  pvm_pkg::state_e state_q, state_d;
  logic [SLOT_W-1:0] k_q, k_d;
  logic [RX_AW-1:0]  i_q, i_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  left_q, left_d;
  logic              phase_q, phase_d;
  logic [ID_W-1:0]   id_q, id_d;

  logic [pvm_pkg::SLOT_FW-1:0] out_slot_q, out_slot_d;
  logic [ID_W-1:0]             out_id_q, out_id_d;
  logic                        out_last_q, out_last_d;

  logic              k_end;
  logic [SLOT_W-1:0] k_inc;
  logic              i_end;
  logic [CNT_W-1:0]  left_m1;
  logic              hit;
  logic              fill_hit;
  logic [SX_W-1:0]   k_x;

  assign k_end    = (k_q == SLOT_W'(TABLE_SLOTS - 1));
  assign k_inc    = k_end ? '0 : k_q + SLOT_W'(1);
  assign i_end    = ((CNT_W'(i_q) + CNT_W'(1)) == cnt_q);
  assign left_m1  = left_q - CNT_W'(1);
  assign hit      = (tbl_ent.id == id_q);
  assign fill_hit = phase_q ? tbl_ent.mark : (tbl_ent.id == pvm_pkg::ID_EMPTY);
  assign k_x      = SX_W'(k_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pvm_pkg::ST_IDLE: begin
        if (in_acc && s_axis_tuser == pvm_pkg::MODE_RECV && s_axis_tlast) begin
          state_d = pvm_pkg::ST_M_RD;
        end
      end
      pvm_pkg::ST_M_RD: state_d = pvm_pkg::ST_M_ID;
      pvm_pkg::ST_M_ID: state_d = pvm_pkg::ST_M_SCAN;
      pvm_pkg::ST_M_SCAN: begin
        if (hit || k_end) begin
          if (!i_end) begin
            state_d = pvm_pkg::ST_M_RD;
          end else if (left_d == '0) begin
            state_d = pvm_pkg::ST_E_RD;
          end else begin
            state_d = pvm_pkg::ST_F_RD;
          end
        end
      end
      pvm_pkg::ST_F_RD: state_d = pvm_pkg::ST_F_WR;
      pvm_pkg::ST_F_WR: begin
        if (left_d == '0 || (k_end && phase_q)) begin
          state_d = pvm_pkg::ST_E_RD;
        end else begin
          state_d = pvm_pkg::ST_F_RD;
        end
      end
      pvm_pkg::ST_E_RD: state_d = pvm_pkg::ST_E_LD;
      pvm_pkg::ST_E_LD: state_d = pvm_pkg::ST_E_OUT;
      pvm_pkg::ST_E_OUT: begin
        if (m_axis_tready) begin
          state_d = k_end ? pvm_pkg::ST_IDLE : pvm_pkg::ST_E_RD;
        end
      end
      default: state_d = pvm_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    k_d        = k_q;
    i_d        = i_q;
    cnt_d      = cnt_q;
    left_d     = left_q;
    phase_d    = phase_q;
    id_d       = id_q;
    out_slot_d = out_slot_q;
    out_id_d   = out_id_q;
    out_last_d = out_last_q;
    tbl_we     = 1'b0;
    tbl_wa     = k_q;
    tbl_wd     = tbl_ent;
    tbl_ra     = k_q;
    rx_we      = 1'b0;
    rx_wa      = cnt_q[RX_AW-1:0];
    rx_wd      = in_id;
    rx_ra      = i_q;
    unique case (state_q)
      pvm_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == pvm_pkg::MODE_SLOT) begin
            if (int'(in_slot) < int'(TABLE_SLOTS)) begin
              tbl_we      = 1'b1;
              tbl_wa      = in_slot_x[SLOT_W-1:0];
              tbl_wd.mark = in_repl;
              tbl_wd.id   = in_id;
            end
          end else begin
            if (cnt_q < CNT_W'(MAX_RECEIVED)) begin
              rx_we = 1'b1;
              cnt_d = cnt_q + CNT_W'(1);
            end
            if (s_axis_tlast) begin
              i_d    = '0;
              left_d = '0;
            end
          end
        end
      end
      pvm_pkg::ST_M_RD: begin
        rx_ra = i_q;
      end
      pvm_pkg::ST_M_ID: begin
        id_d   = rx_rd_q;
        k_d    = '0;
        tbl_ra = '0;
      end
      pvm_pkg::ST_M_SCAN: begin
        tbl_ra = k_inc;
        k_d    = k_inc;
        if (hit) begin
          // known id keeps its slot
          tbl_we      = 1'b1;
          tbl_wd.mark = 1'b0;
        end else if (k_end) begin
          // new id packed in place; left never passes i
          rx_we  = 1'b1;
          rx_wa  = left_q[RX_AW-1:0];
          rx_wd  = id_q;
          left_d = left_q + CNT_W'(1);
        end
        if (hit || k_end) begin
          i_d     = i_q + RX_AW'(1);
          phase_d = 1'b0;
          k_d     = '0;
          if (i_end) begin
            cnt_d = '0;
          end
        end
      end
      pvm_pkg::ST_F_RD: begin
        tbl_ra = k_q;
        rx_ra  = left_m1[RX_AW-1:0];
      end
      pvm_pkg::ST_F_WR: begin
        if (fill_hit) begin
          tbl_we    = 1'b1;
          tbl_wd.id = rx_rd_q;
          left_d    = left_m1;
        end
        k_d = k_inc;
        if (k_end) begin
          phase_d = 1'b1;
        end
        if (left_d == '0 || (k_end && phase_q)) begin
          k_d = '0;
        end
      end
      pvm_pkg::ST_E_RD: begin
        tbl_ra = k_q;
      end
      pvm_pkg::ST_E_LD: begin
        out_slot_d = k_x[pvm_pkg::SLOT_FW-1:0];
        out_id_d   = tbl_ent.id;
        out_last_d = k_end;
      end
      pvm_pkg::ST_E_OUT: begin
        if (m_axis_tready) begin
          k_d = k_inc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pvm_pkg::ST_IDLE;
      k_q     <= '0;
      i_q     <= '0;
      cnt_q   <= '0;
      left_q  <= '0;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      i_q     <= i_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q       <= id_d;
    out_slot_q <= out_slot_d;
    out_id_q   <= out_id_d;
    out_last_q <= out_last_d;
  end

  assign s_axis_tready = (state_q == pvm_pkg::ST_IDLE);
  assign m_axis_tvalid = (state_q == pvm_pkg::ST_E_OUT);
  assign m_axis_tdata  = {2'b00, out_id_q, out_slot_q};
  assign m_axis_tlast  = out_last_q;

endmodule
